// ===== design/avcc_pkg.sv =====
`default_nettype none

package avcc_pkg;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_status;
        logic [2:0]  status_code;
        logic [15:0] total_size;
        logic [2:0]  length_field_size;
        logic        last_result;
    } t_out_word;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_COUNT  = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_DATA   = 3'd4,
        PH_SKIP   = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SMALL = 3'd1;
    localparam logic [2:0] ST_TRUNC_LEN = 3'd2;
    localparam logic [2:0] ST_TRUNC_DAT = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    // what one accepted input byte asks the back end to emit
    typedef struct packed {
        logic        start;
        logic        data;
        logic [7:0]  data_byte;
        logic        status;
        logic [2:0]  code;
        logic [15:0] total;
        logic [2:0]  prefix;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

`default_nettype wire

// ===== design/avcc_front.sv =====
`default_nettype none

module avcc_front
    import avcc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_accept,
    input  wire t_in_word    i_word,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_byte_cnt, n_byte_cnt;
    logic [7:0]  r_sets, n_sets;
    logic        r_doing_pps, n_doing_pps;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [15:0] r_data_left, n_data_left;
    logic [16:0] r_out_count, n_out_count;
    logic [2:0]  r_prefix, n_prefix;
    logic [2:0]  r_err, n_err;
    logic [15:0] r_cap;

    logic [7:0]  b;
    logic [15:0] len;
    logic [17:0] need;
    logic        entry_done;
    logic        list_empty;
    logic [7:0]  sets_next;
    logic [2:0]  code;
    t_cmd        cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
        end else if (i_accept) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt  <= 3'd0;
            r_sets      <= 8'd0;
            r_doing_pps <= 1'b0;
            r_len_hi    <= 8'd0;
            r_data_left <= 16'd0;
            r_out_count <= 17'd0;
            r_prefix    <= 3'd1;
            r_err       <= ST_OK;
        end else if (i_accept) begin
            r_byte_cnt  <= n_byte_cnt;
            r_sets      <= n_sets;
            r_doing_pps <= n_doing_pps;
            r_len_hi    <= n_len_hi;
            r_data_left <= n_data_left;
            r_out_count <= n_out_count;
            r_prefix    <= n_prefix;
            r_err       <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 16'hffff;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    always_comb begin
        b           = i_word.data_byte;
        len         = {r_len_hi, b};
        need        = {1'b0, r_out_count} + 18'd4 + {2'b00, len};
        n_phase     = r_phase;
        n_byte_cnt  = (r_byte_cnt < 3'd7) ? r_byte_cnt + 3'd1 : r_byte_cnt;
        n_sets      = r_sets;
        n_doing_pps = r_doing_pps;
        n_len_hi    = r_len_hi;
        n_data_left = r_data_left;
        n_out_count = r_out_count;
        n_prefix    = r_prefix;
        n_err       = r_err;
        entry_done  = 1'b0;
        cmd         = '0;
        code        = ST_OK;

        case (r_phase)
            PH_HEADER: begin
                if (r_byte_cnt == 3'd4) begin
                    n_prefix = {1'b0, b[1:0]} + 3'd1;
                    n_phase  = PH_COUNT;
                end
            end
            PH_COUNT: begin
                n_sets = r_doing_pps ? b : {3'b000, b[4:0]};
            end
            PH_LEN_HI: begin
                n_len_hi = b;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_data_left = len;
                if (need > {2'b00, r_cap}) begin
                    if (len == 16'd0) begin
                        n_err   = ST_OVERFLOW;
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end else begin
                    cmd.start   = 1'b1;
                    n_out_count = r_out_count + 17'd4;
                    if (len == 16'd0) begin
                        entry_done = 1'b1;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                cmd.data      = 1'b1;
                cmd.data_byte = b;
                n_out_count   = r_out_count + 17'd1;
                n_data_left   = r_data_left - 16'd1;
                if (n_data_left == 16'd0) begin
                    entry_done = 1'b1;
                end
            end
            PH_SKIP: begin
                n_data_left = r_data_left - 16'd1;
                if (n_data_left == 16'd0) begin
                    n_err   = ST_OVERFLOW;
                    n_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase

        // the count byte and a finished entry both pick the next list position
        sets_next  = entry_done ? r_sets - 8'd1 : n_sets;
        list_empty = (sets_next == 8'd0);
        if (entry_done || r_phase == PH_COUNT) begin
            n_sets = sets_next;
            if (!list_empty) begin
                n_phase = PH_LEN_HI;
            end else if (r_doing_pps) begin
                n_phase = PH_DONE;
            end else begin
                n_doing_pps = 1'b1;
                n_phase     = PH_COUNT;
            end
        end

        if (n_byte_cnt < 3'd7) begin
            code = ST_TOO_SMALL;
        end else if (n_err != ST_OK) begin
            code = n_err;
        end else if (n_phase == PH_DATA || n_phase == PH_SKIP) begin
            code = ST_TRUNC_DAT;
        end else if (n_phase == PH_DONE) begin
            code = ST_OK;
        end else begin
            code = ST_TRUNC_LEN;
        end

        if (i_word.last_byte) begin
            cmd.status  = 1'b1;
            cmd.code    = code;
            cmd.total   = (code == ST_OK) ? n_out_count[15:0] : 16'd0;
            cmd.prefix  = n_prefix;
            n_phase     = PH_HEADER;
            n_byte_cnt  = 3'd0;
            n_sets      = 8'd0;
            n_doing_pps = 1'b0;
            n_len_hi    = 8'd0;
            n_data_left = 16'd0;
            n_out_count = 17'd0;
            n_prefix    = 3'd1;
            n_err       = ST_OK;
        end
    end

    assign o_cmd_valid = i_accept && (cmd.start || cmd.data || cmd.status);
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

// ===== design/avcc_queue.sv =====
`default_nettype none

module avcc_queue
    import avcc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_cmd i_wdata,
    input  wire logic i_rd,
    output t_cmd      o_head,
    output t_q_flags  o_flags
);

    localparam int CntW = QPtrW + 1;

    t_cmd             r_mem [QDepth];
    logic [QPtrW-1:0] r_wptr, r_rptr;
    logic [CntW-1:0]  r_count;
    logic             do_wr, do_rd;

    assign do_wr = i_wr && !o_flags.full;
    assign do_rd = i_rd && !o_flags.empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= r_wptr + QPtrW'(1);
            end
            if (do_rd) begin
                r_rptr <= r_rptr + QPtrW'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CntW'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

    assign o_head        = r_mem[r_rptr];
    assign o_flags.full  = (r_count == CntW'(QDepth));
    assign o_flags.empty = (r_count == '0);

endmodule

`default_nettype wire

// ===== design/avcc_back.sv =====
`default_nettype none

module avcc_back
    import avcc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_head,
    input  wire logic i_q_empty,
    input  wire logic i_pop,
    output logic      o_q_pop,
    output t_out_word o_word
);

    logic [1:0] r_sub, n_sub;
    logic       r_body_done, n_body_done;
    logic       in_body;
    logic       pop_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub       <= 2'd0;
            r_body_done <= 1'b0;
        end else begin
            r_sub       <= n_sub;
            r_body_done <= n_body_done;
        end
    end

    always_comb begin
        in_body     = (i_head.start || i_head.data) && !r_body_done;
        pop_ok      = i_pop && !i_q_empty;
        n_sub       = r_sub;
        n_body_done = r_body_done;
        o_q_pop     = 1'b0;
        o_word      = '0;

        if (in_body && i_head.start) begin
            o_word.out_byte    = (r_sub == 2'd3) ? 8'd1 : 8'd0;
            o_word.last_result = (r_sub == 2'd3) && !i_head.status;
        end else if (in_body) begin
            o_word.out_byte    = i_head.data_byte;
            o_word.last_result = !i_head.status;
        end else begin
            o_word.is_status         = 1'b1;
            o_word.status_code       = i_head.code;
            o_word.total_size        = i_head.total;
            o_word.length_field_size = i_head.prefix;
            o_word.last_result       = 1'b1;
        end

        // step through start code, data and status of the head entry
        if (pop_ok) begin
            if (in_body && i_head.start && r_sub != 2'd3) begin
                n_sub = r_sub + 2'd1;
            end else if (in_body && i_head.status) begin
                n_body_done = 1'b1;
            end else begin
                o_q_pop     = 1'b1;
                n_sub       = 2'd0;
                n_body_done = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/avcc_param_sets_to_annexb_top.sv =====
// each taken byte's command is registered into the queue; output words come
// combinationally from its head. throughput: one input byte per cycle unless
// the queue is full; a start code is four words paced by the single output port,
// while a four-entry queue absorbs the burst. reset: synchronous active-low;
// clears the parser, queue and output sequencer; sets the output capacity to 65535
`default_nettype none

module avcc_param_sets_to_annexb_top
    import avcc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire t_in_word    i_in_word,
    output logic             empty,
    input  wire logic        pop,
    output t_out_word        o_out_word
);

    logic     accept;
    logic     cmd_valid;
    t_cmd     cmd;
    t_cmd     head;
    t_q_flags q_flags;
    logic     q_pop;

    assign accept = push && !q_flags.full;
    assign full   = q_flags.full;
    assign empty  = q_flags.empty;

    avcc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_word      (i_in_word),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    avcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_valid),
        .i_wdata (cmd),
        .i_rd    (q_pop),
        .o_head  (head),
        .o_flags (q_flags)
    );

    avcc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_q_empty (q_flags.empty),
        .i_pop     (pop),
        .o_q_pop   (q_pop),
        .o_word    (o_out_word)
    );

`ifndef SYNTHESIS
    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_word.is_status) |-> o_out_word.last_result)
        else $error("status word without last_result");

    a_byte_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_word.is_status) |->
        (o_out_word.status_code == ST_OK && o_out_word.total_size == 16'd0 &&
         o_out_word.length_field_size == 3'd0))
        else $error("byte word carries status fields");

    a_queue_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (pop && !empty && o_out_word.last_result))
        else $error("queue entry retired before its last word");

    a_empty_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> empty)
        else $error("result queue not empty after reset");
`endif

endmodule

`default_nettype wire
